/* hdl/ipr_pkg.sv */
// ----------------------------------------------------------------------------
// ipr_pkg
// Shared widths, constants, types and helpers for the interval product
// renormalizer.
// ----------------------------------------------------------------------------
package ipr_pkg;

    localparam int SCALE_BITS = 16;
    localparam int VAL_W      = SCALE_BITS + 1;       // interval bounds, 0 .. 2^S
    localparam int WORD_W     = 16;                   // emitted word
    localparam int PROD_W     = 2 * VAL_W;            // narrowing products
    localparam int INT_W      = PROD_W - SCALE_BITS;  // integer part of a product

    localparam logic [VAL_W-1:0] ONE_VAL = VAL_W'(1) << SCALE_BITS;

    typedef struct packed {
        logic             start_req;
        logic [VAL_W-1:0] sub_low;
        logic [VAL_W-1:0] sub_high;
    } t_step_req;

    typedef struct packed {
        logic              emit_valid;
        logic [WORD_W-1:0] emitted_word;
        logic [VAL_W-1:0]  cur_low;
        logic [VAL_W-1:0]  cur_high;
    } t_step_res;

    function automatic logic [VAL_W-1:0] sat_scale(input logic [VAL_W-1:0] v);
        return (v > ONE_VAL) ? ONE_VAL : v;
    endfunction

endpackage

/* hdl/ipr_if.sv */
// ----------------------------------------------------------------------------
// ipr_in_if / ipr_out_if
// Valid/ready channels carrying sub-intervals in and step results out.
// ----------------------------------------------------------------------------
interface ipr_in_if import ipr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             start_req;
    logic [VAL_W-1:0] sub_low;
    logic [VAL_W-1:0] sub_high;

    modport source (output valid, output start_req, output sub_low, output sub_high,
                    input ready);
    modport sink   (input valid, input start_req, input sub_low, input sub_high,
                    output ready);
endinterface

interface ipr_out_if import ipr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              emit_valid;
    logic [WORD_W-1:0] emitted_word;
    logic [VAL_W-1:0]  cur_low;
    logic [VAL_W-1:0]  cur_high;

    modport source (output valid, output emit_valid, output emitted_word,
                    output cur_low, output cur_high, input ready);
    modport sink   (input valid, input emit_valid, input emitted_word,
                    input cur_low, input cur_high, output ready);
endinterface

/* hdl/ipr_in_reg.sv */
// ----------------------------------------------------------------------------
// ipr_in_reg
// Input register: captures one sub-interval per transfer and holds it until
// the narrowing stage takes it.
// ----------------------------------------------------------------------------
module ipr_in_reg import ipr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ipr_in_if.sink    i_in,
    input  logic      i_advance,
    output logic      o_valid,
    output t_step_req o_req
);

    logic      r_valid;
    logic      n_valid;
    t_step_req r_req;

    assign i_in.ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (i_in.ready) begin
            n_valid = i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_req.start_req <= i_in.start_req;
            r_req.sub_low   <= i_in.sub_low;
            r_req.sub_high  <= i_in.sub_high;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

/* hdl/ipr_narrow.sv */
// ----------------------------------------------------------------------------
// ipr_narrow
// One narrowing step: two products of the range by the sub-interval bounds,
// then renormalization and word emission.
// ----------------------------------------------------------------------------
module ipr_narrow import ipr_pkg::*; (
    input  logic [VAL_W-1:0] i_low,
    input  logic [VAL_W-1:0] i_high,
    input  t_step_req        i_req,
    output t_step_res        o_res
);

    logic [VAL_W-1:0]      w_sl;
    logic [VAL_W-1:0]      w_sh;
    logic [VAL_W-1:0]      w_range;
    logic [PROD_W-1:0]     w_base;
    logic [PROD_W-1:0]     w_mul_l;
    logic [PROD_W-1:0]     w_mul_r;
    logic [PROD_W-1:0]     w_pl;
    logic [PROD_W-1:0]     w_pr;
    logic [INT_W-1:0]      w_l;
    logic [INT_W-1:0]      w_r;
    logic [INT_W-1:0]      w_l1;
    logic [SCALE_BITS-1:0] w_frac_l;
    logic [SCALE_BITS-1:0] w_frac_r;
    logic [VAL_W-1:0]      w_gap_l;

    always_comb begin
        w_sl = sat_scale(i_req.sub_low);
        w_sh = sat_scale(i_req.sub_high);
        if (w_sh < w_sl) begin
            w_sh = w_sl;
        end
    end

    assign w_range  = (i_high > i_low) ? (i_high - i_low) : '0;
    assign w_base   = PROD_W'({i_low, {SCALE_BITS{1'b0}}});
    assign w_mul_l  = w_range * w_sl;
    assign w_mul_r  = w_range * w_sh;
    assign w_pl     = w_base + w_mul_l;
    assign w_pr     = w_base + w_mul_r;
    assign w_l      = w_pl[PROD_W-1:SCALE_BITS];
    assign w_r      = w_pr[PROD_W-1:SCALE_BITS];
    assign w_l1     = w_l + INT_W'(1);
    assign w_frac_l = w_pl[SCALE_BITS-1:0];
    assign w_frac_r = w_pr[SCALE_BITS-1:0];
    // distance from PL up to the next integer boundary
    assign w_gap_l  = ONE_VAL - VAL_W'(w_frac_l);

    always_comb begin
        o_res = '0;
        if (i_req.start_req) begin
            o_res.cur_low  = w_sl;
            o_res.cur_high = w_sh;
        end else if (w_r > w_l1) begin
            // wide interval: round low up, no word
            o_res.cur_low  = (w_frac_l == '0) ? VAL_W'(w_l) : VAL_W'(w_l1);
            o_res.cur_high = VAL_W'(w_r);
        end else if (w_r == w_l1) begin
            o_res.emit_valid = 1'b1;
            if (w_gap_l >= VAL_W'(w_frac_r)) begin
                o_res.emitted_word = WORD_W'(w_l);
                o_res.cur_low      = VAL_W'(w_frac_l);
                o_res.cur_high     = ONE_VAL;
            end else begin
                o_res.emitted_word = WORD_W'(w_l1);
                o_res.cur_low      = '0;
                o_res.cur_high     = VAL_W'(w_frac_r);
            end
        end else begin
            // both ends share the integer part: emit it, keep the fractions
            o_res.emit_valid   = 1'b1;
            o_res.emitted_word = WORD_W'(w_l);
            o_res.cur_low      = VAL_W'(w_frac_l);
            o_res.cur_high     = VAL_W'(w_frac_r);
        end
    end

endmodule

/* hdl/interval_product_renormalizer_top.sv */
// ----------------------------------------------------------------------------
// interval_product_renormalizer_top
// Running arithmetic-coding interval: loads or narrows by each sub-interval
// and emits a 16-bit word whenever the interval renormalizes.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  i_in     in   valid/ready   start_req, sub_low, sub_high
//  o_out    out  valid/ready   emit_valid, emitted_word, cur_low, cur_high
//
// One item per cycle sustained while the output does not stall; after its
// transfer an item waits in the input register, then moves to the result register.
// The interval register updates as an item moves into the result register,
// so the next item in the input register already sees it.
// Reset clears the interval to [0, 2^SCALE_BITS] and empties both stages.
// A stalled output holds its result; the input stage takes one more item.
// ----------------------------------------------------------------------------
module interval_product_renormalizer_top import ipr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ipr_in_if.sink    i_in,
    ipr_out_if.source o_out
);

    logic             w_s1_valid;
    t_step_req        w_s1_req;
    t_step_res        w_res;
    logic             w_advance;

    logic [VAL_W-1:0] r_int_low;
    logic [VAL_W-1:0] r_int_high;
    logic             r_out_valid;
    logic             n_out_valid;
    t_step_res        r_out;

    assign w_advance = w_s1_valid && (!r_out_valid || o_out.ready);

    ipr_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (w_advance),
        .o_valid   (w_s1_valid),
        .o_req     (w_s1_req)
    );

    ipr_narrow u_narrow (
        .i_low  (r_int_low),
        .i_high (r_int_high),
        .i_req  (w_s1_req),
        .o_res  (w_res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_int_low   <= '0;
            r_int_high  <= ONE_VAL;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_advance) begin
                r_int_low  <= w_res.cur_low;
                r_int_high <= w_res.cur_high;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.emit_valid   = r_out.emit_valid;
    assign o_out.emitted_word = r_out.emitted_word;
    assign o_out.cur_low      = r_out.cur_low;
    assign o_out.cur_high     = r_out.cur_high;

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives sub-intervals into the interval product renormalizer and checks every
// step result against a cycle-free model of the running interval: directed
// loads, saturation, the three renormalization outcomes, full-scale emission,
// then random load/narrow sequences with random source and sink stalls.
// ----------------------------------------------------------------------------
module testbench;
    import ipr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          RANDOM_STEPS = 850;
    localparam int unsigned MAX_BOUND    = 32'h1FFFF;
    localparam int unsigned FULL_SCALE   = 32'd1 << SCALE_BITS;

    logic i_clk;
    logic i_rst_n;

    ipr_in_if  in_ch ();
    ipr_out_if out_ch ();

    interval_product_renormalizer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // running interval as the model sees it
    logic [VAL_W-1:0] run_low  = '0;
    logic [VAL_W-1:0] run_high = ONE_VAL;

    t_step_res   step_results_due[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          gaps_on     = 1'b0;
    int          stall_left  = 0;

    always #2ns i_clk = ~i_clk;

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.start_req = 1'b0;
        in_ch.sub_low   = '0;
        in_ch.sub_high  = '0;
        out_ch.ready    = 1'b1;
    end

    function automatic logic [63:0] clamp_bound(input logic [VAL_W-1:0] v);
        return (v > ONE_VAL) ? 64'(ONE_VAL) : 64'(v);
    endfunction

    // Advance the running interval by one step and return the step result.
    function automatic t_step_res narrow_interval(input t_step_req req);
        logic [63:0] sub_lo;
        logic [63:0] sub_hi;
        logic [63:0] base;
        logic [63:0] span;
        logic [63:0] prod_lo;
        logic [63:0] prod_hi;
        logic [63:0] int_lo;
        logic [63:0] int_hi;
        logic [63:0] r_base;
        logic [63:0] next_low;
        logic [63:0] next_high;
        logic [63:0] word;
        t_step_res   res;

        res    = '0;
        word   = '0;
        sub_lo = clamp_bound(req.sub_low);
        sub_hi = clamp_bound(req.sub_high);
        if (sub_hi < sub_lo) begin
            sub_hi = sub_lo;
        end

        if (req.start_req) begin
            run_low  = sub_lo[VAL_W-1:0];
            run_high = sub_hi[VAL_W-1:0];
        end else begin
            base    = 64'(run_low);
            span    = (run_high > run_low) ? 64'(run_high) - base : 64'd0;
            prod_lo = (base << SCALE_BITS) + span * sub_lo;
            prod_hi = (base << SCALE_BITS) + span * sub_hi;
            int_lo  = prod_lo >> SCALE_BITS;
            int_hi  = prod_hi >> SCALE_BITS;

            if (int_hi > int_lo + 1) begin
                // round the low bound up, nothing to emit yet
                next_low  = (prod_lo == (int_lo << SCALE_BITS)) ? int_lo : int_lo + 1;
                next_high = int_hi;
            end else if (int_hi == int_lo + 1) begin
                // straddles an integer: keep the larger fractional side
                r_base = int_hi << SCALE_BITS;
                if (r_base - prod_lo >= prod_hi - r_base) begin
                    next_low  = prod_lo - (int_lo << SCALE_BITS);
                    next_high = 64'(ONE_VAL);
                    word      = int_lo;
                end else begin
                    next_low  = 64'd0;
                    next_high = prod_hi - r_base;
                    word      = int_lo + 1;
                end
                res.emit_valid = 1'b1;
            end else begin
                next_low       = prod_lo - (int_lo << SCALE_BITS);
                next_high      = prod_hi - (int_lo << SCALE_BITS);
                word           = int_lo;
                res.emit_valid = 1'b1;
            end
            run_low  = next_low[VAL_W-1:0];
            run_high = next_high[VAL_W-1:0];
        end

        res.emitted_word = word[WORD_W-1:0];
        res.cur_low      = run_low;
        res.cur_high     = run_high;
        return res;
    endfunction

    // Present one step at the falling edge and hold it until the transfer.
    task automatic send_step(input bit start, input int unsigned lo, input int unsigned hi);
        t_step_req req;
        int        gap;

        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap         = $urandom_range(1, 11);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req.start_req   = start;
        req.sub_low     = lo[VAL_W-1:0];
        req.sub_high    = hi[VAL_W-1:0];
        in_ch.valid     <= 1'b1;
        in_ch.start_req <= req.start_req;
        in_ch.sub_low   <= req.sub_low;
        in_ch.sub_high  <= req.sub_high;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        step_results_due = {step_results_due, narrow_interval(req)};
        @(negedge i_clk);
    endtask

    // Sink side: random ready stalls.
    always @(negedge i_clk) begin
        if (stall_left == 0 && gaps_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 11);
        end
        if (stall_left != 0) begin
            out_ch.ready <= 1'b0;
            stall_left   = stall_left - 1;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        t_step_res want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (step_results_due.size() == 0) begin
                error_count++;
                $display("%0t: result with none pending, actual word %0d low %0d high %0d",
                         $time, out_ch.emitted_word, out_ch.cur_low, out_ch.cur_high);
            end else begin
                want = step_results_due.pop_front();
                check_field("emit_valid", 32'(want.emit_valid), 32'(out_ch.emit_valid));
                check_field("emitted_word", 32'(want.emitted_word),
                            32'(out_ch.emitted_word));
                check_field("cur_low", 32'(want.cur_low), 32'(out_ch.cur_low));
                check_field("cur_high", 32'(want.cur_high), 32'(out_ch.cur_high));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Narrow straight from the reset interval, with no load first.
    task automatic test_reset_interval();
        send_step(1'b0, 0, FULL_SCALE);
        send_step(1'b0, 16384, 16400);
        send_step(1'b0, 0, FULL_SCALE);
    endtask

    // Saturated, inverted and zero-width loads and sub-intervals.
    task automatic test_bound_extremes();
        send_step(1'b1, MAX_BOUND, MAX_BOUND);
        send_step(1'b0, 0, 0);
        send_step(1'b1, FULL_SCALE + 1, 0);
        send_step(1'b1, 0, MAX_BOUND);
        send_step(1'b0, 50000, 10);
        send_step(1'b1, 40000, 100);
        send_step(1'b1, 0, 0);
        send_step(1'b0, MAX_BOUND, 0);
        send_step(1'b1, 12345, 12345);
        send_step(1'b0, 0, FULL_SCALE);
    endtask

    // Each renormalization outcome from the interval [100, 102].
    task automatic test_renorm_outcomes();
        send_step(1'b1, 100, 102);
        send_step(1'b0, 0, FULL_SCALE);
        send_step(1'b0, 16384, 49152);
        send_step(1'b1, 100, 102);
        send_step(1'b0, 30000, 65000);
        send_step(1'b1, 100, 102);
        send_step(1'b0, 1000, 2000);
    endtask

    // An emitted value of full scale wraps to zero in the word.
    task automatic test_full_scale_emit();
        send_step(1'b1, FULL_SCALE, FULL_SCALE);
        send_step(1'b0, 12345, 54321);
        send_step(1'b1, FULL_SCALE - 1, FULL_SCALE);
        send_step(1'b0, FULL_SCALE, FULL_SCALE);
    endtask

    // Mostly load-then-narrow sequences, with some out-of-range noise.
    task automatic test_random_sequences(input int count);
        int unsigned a;
        int unsigned b;
        int          kind;

        for (int i = 0; i < count; i++) begin
            if (i >= count - 150) begin
                gaps_on = 1'b0;
            end else if (i % 100 == 0) begin
                gaps_on = ($urandom_range(0, 3) != 0);
            end

            if (i == 0 || $urandom_range(0, 11) == 0) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_step(1'b1, $urandom_range(0, MAX_BOUND), $urandom_range(0, MAX_BOUND));
                end else begin
                    a = $urandom_range(0, FULL_SCALE);
                    b = a + $urandom_range(0, FULL_SCALE - a);
                    send_step(1'b1, a, b);
                end
            end else begin
                kind = $urandom_range(0, 9);
                a    = $urandom_range(0, FULL_SCALE);
                if (kind == 0) begin
                    a = $urandom_range(0, MAX_BOUND);
                    b = $urandom_range(0, MAX_BOUND);
                end else if (kind <= 3) begin
                    b = a + $urandom_range(0, 256);
                end else if (kind <= 6) begin
                    b = a + $urandom_range(0, 8192);
                end else begin
                    a = $urandom_range(0, FULL_SCALE / 2);
                    b = $urandom_range(a, FULL_SCALE);
                end
                if (kind != 0 && b > FULL_SCALE) begin
                    b = FULL_SCALE;
                end
                send_step(1'b0, a, b);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        gaps_on = 1'b1;

        test_reset_interval();
        test_bound_extremes();
        test_renorm_outcomes();
        test_full_scale_emit();
        test_random_sequences(RANDOM_STEPS);

        in_ch.valid <= 1'b0;
        gaps_on = 1'b0;
        while (step_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/ipr_pkg.sv
hdl/ipr_if.sv
hdl/ipr_in_reg.sv
hdl/ipr_narrow.sv
hdl/interval_product_renormalizer_top.sv
verif/testbench.sv
